// ===== rtl/scalar_sample_interpolator_defines.svh =====
// assertion macros used by the checker module ssi_checker
`ifndef SCALAR_SAMPLE_INTERPOLATOR_DEFINES_SVH
`define SCALAR_SAMPLE_INTERPOLATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SSI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssi check failed");

// next-cycle implication, checked outside reset
`define SSI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssi check failed");

`endif

// ===== rtl/ssi_pkg.sv =====
package ssi_pkg;

  // operation codes of an input item
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_LINEAR = 2'd2,
    OP_CUBIC  = 2'd3
  } opcode_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNSORTED = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FEW      = 3'd3,
    ST_FULL     = 3'd4,
    ST_DEGEN    = 3'd5
  } status_t;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    DP_NOP,
    DP_TAKE,
    DP_CLEAR,
    DP_APPEND,
    DP_FIX_STALE,
    DP_RD_NEXT,
    DP_CUR_INC,
    DP_RD_CUR,
    DP_CUR_DEC,
    DP_CLAMP,
    DP_LOAD,
    DP_TERM_INIT,
    DP_MUL_INIT,
    DP_MUL_STEP,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_ACC_ADD,
    DP_PUBLISH
  } dp_op_t;

  // controller states
  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_APP_DONE,
    S_STALE,
    S_FWD,
    S_FWD_WAIT,
    S_BACK,
    S_BACK_WAIT,
    S_CHECK,
    S_LOAD,
    S_TERM,
    S_MUL_INIT,
    S_MUL,
    S_DIV_INIT,
    S_DIV,
    S_ACC,
    S_FINISH
  } state_t;

  typedef struct packed {
    dp_op_t  op;
    status_t code;
  } cmd_t;

  typedef struct packed {
    opcode_t opc;
    logic    sorted;
    logic    empty;
    logic    full;
    logic    few_lin;
    logic    few_cub;
    logic    stale;
    logic    can_fwd;
    logic    can_back;
    logic    t_before;
    logic    load_done;
    logic    deg;
    logic    mul_done;
    logic    last_inner;
    logic    div_done;
    logic    last_term;
    logic    out_free;
  } dp_sts_t;

endpackage

// ===== rtl/ssi_ctrl.sv =====
module ssi_ctrl
  import ssi_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output cmd_t    cmd
);

  state_t  state_r, state_nxt;
  status_t code_r, code_nxt;

  // state and pending status code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd.op    = DP_NOP;
    cmd.code  = code_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = DP_TAKE;
          code_nxt  = ST_OK;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.opc)
          OP_CLEAR: begin
            cmd.op    = DP_CLEAR;
            state_nxt = S_FINISH;
          end
          OP_APPEND: begin
            if (sts.full) begin
              code_nxt  = ST_FULL;
              state_nxt = S_FINISH;
            end else begin
              cmd.op    = DP_APPEND;
              state_nxt = S_APP_DONE;
            end
          end
          default: begin
            if (!sts.sorted) begin
              code_nxt  = ST_UNSORTED;
              state_nxt = S_FINISH;
            end else if (sts.empty) begin
              code_nxt  = ST_EMPTY;
              state_nxt = S_FINISH;
            end else begin
              state_nxt = S_STALE;
            end
          end
        endcase
      end
      S_APP_DONE: begin
        code_nxt  = sts.sorted ? ST_OK : ST_UNSORTED;
        state_nxt = S_FINISH;
      end
      S_STALE: begin
        if (sts.stale) cmd.op = DP_FIX_STALE;
        state_nxt = S_FWD;
      end
      // forward walk, one read per step
      S_FWD: begin
        if (sts.can_fwd) begin
          cmd.op    = DP_RD_NEXT;
          state_nxt = S_FWD_WAIT;
        end else begin
          state_nxt = S_BACK;
        end
      end
      S_FWD_WAIT: begin
        if (!sts.t_before) begin
          cmd.op    = DP_CUR_INC;
          state_nxt = S_FWD;
        end else begin
          state_nxt = S_BACK;
        end
      end
      // backward walk
      S_BACK: begin
        if (sts.can_back) begin
          cmd.op    = DP_RD_CUR;
          state_nxt = S_BACK_WAIT;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_BACK_WAIT: begin
        if (sts.t_before) begin
          cmd.op    = DP_CUR_DEC;
          state_nxt = S_BACK;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if ((sts.opc == OP_LINEAR && sts.few_lin) || (sts.opc == OP_CUBIC && sts.few_cub)) begin
          code_nxt  = ST_FEW;
          state_nxt = S_FINISH;
        end else begin
          cmd.op    = DP_CLAMP;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.op = DP_LOAD;
        if (sts.load_done) state_nxt = S_TERM;
      end
      S_TERM: begin
        cmd.op    = DP_TERM_INIT;
        state_nxt = S_MUL_INIT;
      end
      S_MUL_INIT: begin
        if (sts.deg) begin
          code_nxt  = ST_DEGEN;
          state_nxt = S_FINISH;
        end else begin
          cmd.op    = DP_MUL_INIT;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op = DP_MUL_STEP;
        if (sts.mul_done) state_nxt = sts.last_inner ? S_DIV_INIT : S_MUL_INIT;
      end
      S_DIV_INIT: begin
        cmd.op    = DP_DIV_INIT;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = DP_DIV_STEP;
        if (sts.div_done) state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op    = DP_ACC_ADD;
        state_nxt = sts.last_term ? S_FINISH : S_TERM;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.op    = DP_PUBLISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/ssi_dp.sv =====
module ssi_dp
  import ssi_pkg::*;
#(
  parameter int DEPTH      = 1024,
  parameter int TIME_BITS  = 48,
  parameter int VALUE_BITS = 32,
  localparam int IDX_W     = $clog2(DEPTH),
  localparam int CNT_W     = IDX_W + 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   in_opcode,
  input  logic [TIME_BITS-1:0]         in_time_stamp,
  input  logic signed [VALUE_BITS-1:0] in_sample_value,
  input  cmd_t                         cmd,
  output dp_sts_t                      sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [VALUE_BITS-1:0] out_result_value,
  output logic [2:0]                   out_status,
  output logic [CNT_W-1:0]             out_stored_count
);

  localparam int TB     = TIME_BITS;
  localparam int VB     = VALUE_BITS;
  localparam int NUM_W  = VB + 3 * TB;
  localparam int DEN_W  = 3 * TB;
  localparam int DD_W   = NUM_W + 2;
  localparam int DV_W   = DEN_W + 1;
  localparam int ACC_W  = DD_W + 3;
  localparam int MC_W   = $clog2(TB);
  localparam int DC_W   = $clog2(DD_W);

  // sample memories, undefined until written
  logic [TB-1:0] tmem [DEPTH];
  logic [VB-1:0] vmem [DEPTH];
  logic [TB-1:0] rd_t_q;
  logic [VB-1:0] rd_v_q;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;

  // table state
  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] cur_r, base_r;
  logic             sorted_r;
  logic [TB-1:0]    last_t_r;

  // item registers
  opcode_t       opc_r;
  logic [TB-1:0] t_r;
  logic [VB-1:0] v_r;

  // working samples
  logic [TB-1:0] rt_r [4];
  logic [VB-1:0] rv_r [4];
  logic [TB-1:0] wk_r [3];
  logic [2:0]    ld_k_r;
  logic [1:0]    ti_r, jn_r;

  // arithmetic registers
  logic [NUM_W-1:0]        num_r, mc_n_r;
  logic [DEN_W-1:0]        den_r, mc_d_r;
  logic [TB-1:0]           mp_a_r, mp_b_r;
  logic [MC_W-1:0]         mcnt_r;
  logic                    neg_r;
  logic [DD_W-1:0]         dd_r, q_r;
  logic [DV_W-1:0]         dv_r, rem_r;
  logic [DC_W-1:0]         dcnt_r;
  logic signed [ACC_W-1:0] acc_r;

  logic                    out_valid_r;
  logic [VB-1:0]           out_val_r;
  logic [2:0]              out_st_r;
  logic [CNT_W-1:0]        out_cnt_r;

  logic             cubic;
  logic [1:0]       n_m1;
  logic [CNT_W-1:0] cur_ext;
  logic [IDX_W-1:0] clamp_cur;
  logic [TB-1:0]    dif_a, dif_b;
  logic             sa, sb;
  logic [DV_W:0]    rshift;
  logic             ge;
  logic signed [ACC_W-1:0] q_s, sat_max, sat_min;
  logic [VB-1:0]    sat_val;
  logic [VB-1:0]    y_mag;

  assign cubic   = (opc_r == OP_CUBIC);
  assign n_m1    = cubic ? 2'd3 : 2'd1;
  assign cur_ext = {1'b0, cur_r};

  // read address per command
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = cur_r;
    unique case (cmd.op)
      DP_RD_NEXT: rd_addr = cur_r + IDX_W'(1);
      DP_RD_CUR:  rd_addr = cur_r;
      DP_LOAD:    rd_addr = base_r + IDX_W'(ld_k_r);
      default:    rd_en   = 1'b0;
    endcase
  end

  // sample memory ports
  always_ff @(posedge clk) begin
    if (cmd.op == DP_APPEND) begin
      tmem[cnt_r[IDX_W-1:0]] <= t_r;
      vmem[cnt_r[IDX_W-1:0]] <= v_r;
    end
    if (rd_en) begin
      rd_t_q <= tmem[rd_addr];
      rd_v_q <= vmem[rd_addr];
    end
  end

  // cursor clamp for the selected window
  always_comb begin
    clamp_cur = cur_r;
    if (!cubic) begin
      if (cur_ext + CNT_W'(1) >= cnt_r) clamp_cur = IDX_W'(cnt_r - CNT_W'(2));
    end else if (cur_r == '0) begin
      clamp_cur = IDX_W'(1);
    end else if (cur_ext + CNT_W'(3) >= cnt_r) begin
      clamp_cur = IDX_W'(cnt_r - CNT_W'(3));
    end
  end

  // time differences for the current product step
  assign sa    = t_r < wk_r[0];
  assign dif_a = sa ? wk_r[0] - t_r : t_r - wk_r[0];
  assign sb    = rt_r[0] < wk_r[0];
  assign dif_b = sb ? wk_r[0] - rt_r[0] : rt_r[0] - wk_r[0];
  assign y_mag = rv_r[0][VB-1] ? VB'(-rv_r[0]) : rv_r[0];

  // restoring divide step
  assign rshift = {rem_r, dd_r[DD_W-1]};
  assign ge     = rshift >= {1'b0, dv_r};

  // signed quotient and saturation
  assign q_s     = neg_r ? -$signed({3'b000, q_r}) : $signed({3'b000, q_r});
  assign sat_max = ACC_W'({1'b0, {(VB-1){1'b1}}});
  assign sat_min = -sat_max - ACC_W'(1);
  always_comb begin
    priority if (acc_r > sat_max) sat_val = sat_max[VB-1:0];
    else if (acc_r < sat_min) sat_val = sat_min[VB-1:0];
    else sat_val = acc_r[VB-1:0];
  end

  // control state of the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      cur_r       <= '0;
      sorted_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      // result handshake
      if (cmd.op == DP_PUBLISH) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (cmd.op)
        DP_CLEAR: begin
          cnt_r    <= '0;
          cur_r    <= '0;
          sorted_r <= 1'b1;
        end
        DP_APPEND: begin
          if (cnt_r != '0 && t_r < last_t_r) sorted_r <= 1'b0;
          cnt_r <= cnt_r + CNT_W'(1);
        end
        DP_FIX_STALE: cur_r <= IDX_W'(cnt_r - CNT_W'(1));
        DP_CUR_INC:   cur_r <= cur_r + IDX_W'(1);
        DP_CUR_DEC:   cur_r <= cur_r - IDX_W'(1);
        DP_CLAMP:     cur_r <= clamp_cur;
        default: ;
      endcase
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_TAKE: begin
        opc_r <= opcode_t'(in_opcode);
        t_r   <= in_time_stamp;
        v_r   <= in_sample_value;
        acc_r <= '0;
      end
      DP_APPEND: last_t_r <= t_r;
      DP_CLAMP: begin
        base_r <= cubic ? clamp_cur - IDX_W'(1) : clamp_cur;
        ld_k_r <= '0;
        ti_r   <= '0;
      end
      DP_LOAD: begin
        ld_k_r <= ld_k_r + 3'd1;
        if (ld_k_r != 3'd0) begin
          for (int i = 0; i < 3; i++) begin
            rt_r[i] <= rt_r[i+1];
            rv_r[i] <= rv_r[i+1];
          end
          rt_r[3] <= rd_t_q;
          rv_r[3] <= rd_v_q;
        end
      end
      DP_TERM_INIT: begin
        num_r   <= NUM_W'(y_mag);
        neg_r   <= rv_r[0][VB-1];
        den_r   <= DEN_W'(1);
        jn_r    <= '0;
        wk_r[0] <= rt_r[1];
        wk_r[1] <= rt_r[2];
        wk_r[2] <= rt_r[3];
      end
      DP_MUL_INIT: begin
        mc_n_r  <= num_r;
        mc_d_r  <= den_r;
        num_r   <= '0;
        den_r   <= '0;
        mp_a_r  <= dif_a;
        mp_b_r  <= dif_b;
        mcnt_r  <= '0;
        neg_r   <= neg_r ^ sa ^ sb;
        jn_r    <= jn_r + 2'd1;
        wk_r[0] <= wk_r[1];
        wk_r[1] <= wk_r[2];
        wk_r[2] <= wk_r[0];
      end
      // shift-add multiply, one multiplier bit a cycle
      DP_MUL_STEP: begin
        if (mp_a_r[0]) num_r <= num_r + mc_n_r;
        if (mp_b_r[0]) den_r <= den_r + mc_d_r;
        mc_n_r <= mc_n_r << 1;
        mc_d_r <= mc_d_r << 1;
        mp_a_r <= mp_a_r >> 1;
        mp_b_r <= mp_b_r >> 1;
        mcnt_r <= mcnt_r + MC_W'(1);
      end
      // rounded quotient (2num + den) / (2den)
      DP_DIV_INIT: begin
        dd_r   <= DD_W'({num_r, 1'b0}) + DD_W'(den_r);
        dv_r   <= {den_r, 1'b0};
        rem_r  <= '0;
        q_r    <= '0;
        dcnt_r <= '0;
      end
      DP_DIV_STEP: begin
        rem_r  <= ge ? DV_W'(rshift - {1'b0, dv_r}) : rshift[DV_W-1:0];
        q_r    <= {q_r[DD_W-2:0], ge};
        dd_r   <= dd_r << 1;
        dcnt_r <= dcnt_r + DC_W'(1);
      end
      DP_ACC_ADD: begin
        acc_r <= acc_r + q_s;
        ti_r  <= ti_r + 2'd1;
        if (cubic) begin
          for (int i = 0; i < 3; i++) begin
            rt_r[i] <= rt_r[i+1];
            rv_r[i] <= rv_r[i+1];
          end
          rt_r[3] <= rt_r[0];
          rv_r[3] <= rv_r[0];
        end else begin
          rt_r[0] <= rt_r[1];
          rt_r[1] <= rt_r[0];
          rv_r[0] <= rv_r[1];
          rv_r[1] <= rv_r[0];
        end
      end
      DP_PUBLISH: begin
        out_val_r <= (cmd.code == ST_OK) ? sat_val : '0;
        out_st_r  <= cmd.code;
        out_cnt_r <= cnt_r;
      end
      default: ;
    endcase
  end

  // status to the controller
  always_comb begin
    sts.opc        = opc_r;
    sts.sorted     = sorted_r;
    sts.empty      = (cnt_r == '0);
    sts.full       = cnt_r[IDX_W];
    sts.few_lin    = (cnt_r < CNT_W'(2));
    sts.few_cub    = (cnt_r <= CNT_W'(4));
    sts.stale      = (cur_ext >= cnt_r);
    sts.can_fwd    = (cur_ext + CNT_W'(1) < cnt_r);
    sts.can_back   = (cur_r != '0);
    sts.t_before   = (t_r < rd_t_q);
    sts.load_done  = (ld_k_r == 3'd4);
    sts.deg        = (rt_r[0] == wk_r[0]);
    sts.mul_done   = (mcnt_r == MC_W'(TB - 1));
    sts.last_inner = (jn_r == n_m1);
    sts.div_done   = (dcnt_r == DC_W'(DD_W - 1));
    sts.last_term  = (ti_r == n_m1);
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_val_r;
  assign out_status       = out_st_r;
  assign out_stored_count = out_cnt_r;

endmodule

// ===== rtl/scalar_sample_interpolator.sv =====
// scalar sample interpolator
// input channel in_*: one item per operation, opcode clear, append, linear
// query or cubic query, with a time stamp and a sample value. every item
// gives exactly one result item on out_*: the interpolated value, a status
// code and the number of stored samples.
// a query walks the cursor one step at a time (one memory read and one
// compare per step), loads the window, then per Lagrange term (2 terms
// linear, 4 cubic) runs n-1 passes of the shift-add multipliers and one
// pass of the bit-serial divider.
// one item is worked on at a time; the next item is taken once the result
// sits in the output register, so a finished result may wait there while
// the next item runs. a stalled receiver holds the result and stops the
// block only when a second result is ready to be shown.
// reset empties the table, homes the cursor and marks the table sorted;
// sample memory contents are not cleared.
module scalar_sample_interpolator
  import ssi_pkg::*;
#(
  parameter int DEPTH      = 1024,
  parameter int TIME_BITS  = 48,
  parameter int VALUE_BITS = 32,
  localparam int CNT_W     = $clog2(DEPTH) + 1,
  localparam int IN_W      = ((2 + TIME_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_W     = ((VALUE_BITS + 3 + CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // opcode, time_stamp, sample_value
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // result_value, status, stored_count
);

  cmd_t                         cmd;
  dp_sts_t                      sts;
  logic signed [VALUE_BITS-1:0] res_val;
  logic [2:0]                   res_st;
  logic [CNT_W-1:0]             res_cnt;

  ssi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssi_dp #(
    .DEPTH      (DEPTH),
    .TIME_BITS  (TIME_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_opcode        (in_tdata[1:0]),
    .in_time_stamp    (in_tdata[2 +: TIME_BITS]),
    .in_sample_value  (in_tdata[2 + TIME_BITS +: VALUE_BITS]),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_result_value (res_val),
    .out_status       (res_st),
    .out_stored_count (res_cnt)
  );

  // result packing, zero filled to whole bytes
  assign out_tdata = OUT_W'({res_cnt, res_st, res_val});

endmodule

// ===== rtl/ssi_checker.sv =====
`include "scalar_sample_interpolator_defines.svh"

module ssi_checker #(
  parameter int OUT_W      = 48,
  parameter int VALUE_BITS = 32
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // a stalled result holds
  `SSI_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // one item at a time: an accepted item closes the input
  `SSI_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready)

  // status is one of the defined codes
  `SSI_ASSERT_NOW(a_status_code, out_tvalid, out_tdata[VALUE_BITS+2 -: 2] != 2'b11)

  // a failed operation returns zero
  `SSI_ASSERT_NOW(a_fail_zero, out_tvalid && out_tdata[VALUE_BITS+2 -: 3] != 3'd0, out_tdata[VALUE_BITS-1:0] == '0)

endmodule

bind scalar_sample_interpolator ssi_checker #(
  .OUT_W      (OUT_W),
  .VALUE_BITS (VALUE_BITS)
) u_ssi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== dv/scalar_sample_interpolator_checker.sv =====
`timescale 1ns / 1ps

module scalar_sample_interpolator_checker
  import ssi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [87:0] in_tdata,   // opcode, time_stamp, sample_value
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // result_value, status, stored_count
  output int          fail_count,
  output int          pending
);

  localparam int DEPTH = 1024;

  typedef struct packed {
    logic [10:0] count;
    status_t     status;
    logic [31:0] value;
  } interp_result_t;

  // shadow copy of the sample table
  logic [47:0] shadow_times [DEPTH];
  logic [31:0] shadow_values [DEPTH];
  int          shadow_count;
  int          shadow_cursor;
  logic        shadow_sorted;

  interp_result_t expected_results [$];

  // exact Lagrange sum over the window base .. base+n-1, rounded and saturated
  function automatic logic [31:0] lagrange_value(int base, int n, logic [47:0] t);
    logic [255:0]        acc, num, den, q;
    logic signed [255:0] sacc;
    logic [47:0]         ti, tj, d;
    logic [31:0]         y, r;
    logic                neg;
    acc = '0;
    for (int i = 0; i < n; i++) begin
      y   = shadow_values[base+i];
      ti  = shadow_times[base+i];
      neg = y[31];
      num = {224'b0, neg ? 32'(-y) : y};
      den = 256'd1;
      for (int j = 0; j < n; j++) begin
        if (j != i) begin
          tj = shadow_times[base+j];
          if (t < tj) begin
            d = tj - t;
            neg = !neg;
          end else begin
            d = t - tj;
          end
          num = num * {208'b0, d};
          if (ti < tj) begin
            d = tj - ti;
            neg = !neg;
          end else begin
            d = ti - tj;
          end
          den = den * {208'b0, d};
        end
      end
      q = ((num << 1) + den) / (den << 1);
      if (neg) q = -q;
      acc = acc + q;
    end
    sacc = acc;
    if (sacc > 256'sd2147483647) r = 32'h7fffffff;
    else if (sacc < -256'sd2147483648) r = 32'h80000000;
    else r = acc[31:0];
    return r;
  endfunction

  // true when two samples of the window share a time
  function automatic logic window_degenerate(int base, int n);
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++)
        if (shadow_times[base+i] == shadow_times[base+j]) return 1'b1;
    return 1'b0;
  endfunction

  // apply one operation to the shadow table and give its result
  function automatic interp_result_t interpolate_item(logic [87:0] item);
    interp_result_t res;
    opcode_t        op;
    logic [47:0]    t;
    logic [31:0]    v;
    op = opcode_t'(item[1:0]);
    t  = item[49:2];
    v  = item[81:50];
    res.value  = '0;
    res.status = ST_OK;
    if (op == OP_CLEAR) begin
      shadow_count  = 0;
      shadow_cursor = 0;
      shadow_sorted = 1'b1;
    end else if (op == OP_APPEND) begin
      if (shadow_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        if (shadow_count > 0 && t < shadow_times[shadow_count-1]) shadow_sorted = 1'b0;
        shadow_times[shadow_count]  = t;
        shadow_values[shadow_count] = v;
        shadow_count++;
        res.status = shadow_sorted ? ST_OK : ST_UNSORTED;
      end
    end else if (!shadow_sorted) begin
      res.status = ST_UNSORTED;
    end else if (shadow_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      // cursor walk toward the query time
      if (shadow_cursor >= shadow_count) shadow_cursor = shadow_count - 1;
      while (shadow_cursor + 1 < shadow_count && !(t < shadow_times[shadow_cursor+1]))
        shadow_cursor++;
      while (shadow_cursor > 0 && t < shadow_times[shadow_cursor])
        shadow_cursor--;
      if (op == OP_LINEAR) begin
        if (shadow_count < 2) begin
          res.status = ST_FEW;
        end else begin
          if (shadow_cursor + 1 >= shadow_count) shadow_cursor = shadow_count - 2;
          if (window_degenerate(shadow_cursor, 2)) res.status = ST_DEGEN;
          else res.value = lagrange_value(shadow_cursor, 2, t);
        end
      end else begin
        if (shadow_count <= 4) begin
          res.status = ST_FEW;
        end else begin
          if (shadow_cursor < 1) shadow_cursor = 1;
          else if (shadow_cursor + 3 >= shadow_count) shadow_cursor = shadow_count - 3;
          if (window_degenerate(shadow_cursor - 1, 4)) res.status = ST_DEGEN;
          else res.value = lagrange_value(shadow_cursor - 1, 4, t);
        end
      end
    end
    res.count = 11'(shadow_count);
    return res;
  endfunction

  // watch both channels, predict on input, compare on output
  always @(posedge clk) begin
    interp_result_t got, exp_res;
    if (!rst_n) begin
      shadow_count  = 0;
      shadow_cursor = 0;
      shadow_sorted = 1'b1;
      fail_count    <= 0;
      expected_results.delete();
    end else begin
      if (in_tvalid && in_tready)
        expected_results = {expected_results, interpolate_item(in_tdata)};
      if (out_tvalid && out_tready) begin
        got = out_tdata[45:0];
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result item %h", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_res = expected_results.pop_front();
          if (got.value !== exp_res.value || got.status !== exp_res.status ||
              got.count !== exp_res.count) begin
            if (fail_count < 10)
              $display("mismatch: value %h/%h status %0d/%0d count %0d/%0d (exp/got)",
                       exp_res.value, got.value, exp_res.status, got.status,
                       exp_res.count, got.count);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ===== dv/tb_scalar_sample_interpolator.sv =====
`timescale 1ns / 1ps

module tb_scalar_sample_interpolator;
  import ssi_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;   // opcode, time_stamp, sample_value
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // result_value, status, stored_count
  int          fail_count;
  int          pending;
  int          items_sent;
  int          send_idle_pct;
  int          recv_idle_pct;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  scalar_sample_interpolator dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  scalar_sample_interpolator_checker checker_i (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .fail_count, .pending
  );

  // idling profile follows the progress of the run
  always_comb begin
    if (items_sent < 520) begin
      send_idle_pct = 8;
      recv_idle_pct = 50;
    end else if (items_sent < 1040) begin
      send_idle_pct = 50;
      recv_idle_pct = 8;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // random receiver stalls
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // offer one item and wait for its handshake
  task automatic send_item(opcode_t op, logic [47:0] t, logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, v, t, op};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [47:0] rand_time();
    return {$urandom, $urandom};
  endfunction

  // clear, a sorted run of samples, then queries with some noise
  task automatic sample_run();
    logic [63:0] t, t_first, span;
    int          n, nq;
    logic        big_values;
    send_item(OP_CLEAR, rand_time(), $urandom);
    n = ($urandom_range(9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 12);
    t = ($urandom_range(3) == 0) ? 64'($urandom_range(50)) : 64'(rand_time() >> 2);
    t_first = t;
    big_values = $urandom_range(1);
    for (int i = 0; i < n; i++) begin
      send_item(OP_APPEND, t[47:0], big_values ? $urandom : 32'($signed($urandom_range(0, 131072)) - 65536));
      case ($urandom_range(9))
        0: t = t;
        1, 2: t = t + $urandom;
        default: t = t + $urandom_range(1, 64);
      endcase
    end
    span = t - t_first + 1;
    nq = $urandom_range(2, 8);
    for (int i = 0; i < nq; i++) begin
      case ($urandom_range(9))
        0: send_item(OP_APPEND, rand_time(), $urandom);
        1: send_item(opcode_t'($urandom_range(3)), rand_time(), $urandom);
        2: send_item($urandom_range(1) ? OP_LINEAR : OP_CUBIC, rand_time(), $urandom);
        3: send_item($urandom_range(1) ? OP_LINEAR : OP_CUBIC,
                     48'(t_first - $urandom_range(0, 200)), $urandom);
        default: send_item($urandom_range(1) ? OP_LINEAR : OP_CUBIC,
                           48'(t_first + ({$urandom, $urandom} % (span + 100))), $urandom);
      endcase
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    items_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, too few samples, extremes of time and value
    send_item(OP_LINEAR, 48'hffffffffffff, 32'h0);
    send_item(OP_CUBIC, 48'h0, 32'h0);
    send_item(OP_APPEND, 48'h0, 32'h80000000);
    send_item(OP_LINEAR, 48'h5, 32'h0);
    send_item(OP_CUBIC, 48'h5, 32'h0);
    send_item(OP_APPEND, 48'h10, 32'h7fffffff);
    send_item(OP_LINEAR, 48'h8, 32'hffffffff);
    send_item(OP_LINEAR, 48'hffffffffffff, 32'h0);
    send_item(OP_APPEND, 48'h11, 32'h80000000);
    send_item(OP_APPEND, 48'h11, 32'h00010000);
    send_item(OP_APPEND, 48'h12, 32'h7fffffff);
    send_item(OP_CUBIC, 48'h0, 32'h0);
    send_item(OP_LINEAR, 48'h11, 32'h0);
    send_item(OP_APPEND, 48'hffffffffffff, 32'h80000000);
    send_item(OP_CUBIC, 48'hffffffffffff, 32'h0);
    send_item(OP_LINEAR, 48'h0, 32'h0);
    // time running backwards makes the table unsorted until a clear
    send_item(OP_APPEND, 48'h3, 32'h12345678);
    send_item(OP_APPEND, 48'hffffffffffff, 32'h0);
    send_item(OP_LINEAR, 48'h4, 32'h0);
    send_item(OP_CUBIC, 48'h4, 32'h0);
    send_item(OP_CLEAR, 48'hffffffffffff, 32'hffffffff);
    send_item(OP_LINEAR, 48'h4, 32'h0);

    // random runs, with one fill to a full table on the way
    while (items_sent < 1550) begin
      if (items_sent >= 200 && items_sent < 220) begin
        send_item(OP_CLEAR, 48'h0, 32'h0);
        for (int i = 0; i < 1026; i++) send_item(OP_APPEND, 48'(i * 3), $urandom);
        send_item(OP_LINEAR, 48'hffffffffffff, 32'h0);
        send_item(OP_CUBIC, 48'h0, 32'h0);
        send_item(OP_CUBIC, 48'hffffffffffff, 32'h0);
      end
      sample_run();
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // run limit
  initial begin
    #60_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
